>>> rtl/tcc_pkg.sv
// Shared types, widths and constants of the traversability cost cell.
// No dependencies; every other file of the block imports this package.
package tcc_pkg;

  localparam int unsigned NUM_FEAT   = 5;
  localparam int unsigned SLOPE_W    = 16;
  localparam int unsigned FEAT_W     = 24;
  localparam int unsigned OK_W       = 5;
  localparam int unsigned W_W        = 16;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned OCC_W      = 8;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned COST_W     = 17;
  localparam int unsigned SUM_W      = 29;
  localparam int unsigned U_W        = 21;
  localparam int unsigned MUL_W      = 26;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned ACC_W      = 35;
  localparam int unsigned FRAC_W     = 16;
  // Reciprocals are scaled by 2^RECIP_SHIFT; the quotient sits at bit Q_LSB.
  localparam int unsigned RECIP_SHIFT = 37;
  localparam int unsigned Q_LSB       = RECIP_SHIFT - FRAC_W;

  localparam int unsigned MAX_CELLS  = 4096;
  localparam int unsigned CNT_HW_MAX = 8191;
  localparam int unsigned CNT_CAP_N  = (MAX_CELLS > CNT_HW_MAX) ? CNT_HW_MAX : MAX_CELLS;
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_N);

  localparam logic [COST_W-1:0] ONE_Q16 = COST_W'(65536);
  localparam logic [SUM_W-1:0]  SUM_CAP = SUM_W'(268435456);
  localparam logic [6:0]        OCC_SCALE = 7'd100;
  localparam logic signed [OCC_W-1:0] OCC_UNKNOWN = -8'sd1;
  localparam logic [OK_W-1:0]   ALL_OK = '1;

  // Saturation limits of the features, in input units.
  localparam logic [U_W-1:0] LIM_SLOPE = U_W'(3000);
  localparam logic [U_W-1:0] LIM_ROUGH = U_W'(100000);
  localparam logic [U_W-1:0] LIM_STEP  = U_W'(300000);
  localparam logic [U_W-1:0] LIM_CLEAR = U_W'(2000000);
  localparam logic [U_W-1:0] LIM_VAR   = U_W'(10000);

  // floor(2^37 / limit): the estimate is never high and at most one low.
  localparam logic [MUL_W-1:0] RECIP_SLOPE = MUL_W'((64'd1 << RECIP_SHIFT) / 64'(LIM_SLOPE));
  localparam logic [MUL_W-1:0] RECIP_ROUGH = MUL_W'((64'd1 << RECIP_SHIFT) / 64'(LIM_ROUGH));
  localparam logic [MUL_W-1:0] RECIP_STEP  = MUL_W'((64'd1 << RECIP_SHIFT) / 64'(LIM_STEP));
  localparam logic [MUL_W-1:0] RECIP_CLEAR = MUL_W'((64'd1 << RECIP_SHIFT) / 64'(LIM_CLEAR));
  localparam logic [MUL_W-1:0] RECIP_VAR   = MUL_W'((64'd1 << RECIP_SHIFT) / 64'(LIM_VAR));

  // Feature order; also the register index of the matching weight.
  typedef enum logic [2:0] {
    FEAT_SLOPE,
    FEAT_ROUGH,
    FEAT_STEP,
    FEAT_CLEAR,
    FEAT_VAR
  } feat_e;

  typedef logic [NUM_FEAT-1:0][W_W-1:0] weights_t;

  localparam weights_t WEIGHTS_RST = {16'd6554, 16'd13107, 16'd16384, 16'd13107, 16'd16384};

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope_cdeg;
    logic signed [FEAT_W-1:0]  rough_um;
    logic signed [FEAT_W-1:0]  stepheight_um;
    logic signed [FEAT_W-1:0]  clear_um;
    logic signed [FEAT_W-1:0]  var_mm2;
    logic [OK_W-1:0]           feature_ok;
    logic                      last_cell;
  } cell_t;

  typedef struct packed {
    logic              known;
    logic              last;
    logic [COST_W-1:0] cost;
  } cell_res_t;

  typedef struct packed {
    logic [CNT_W-1:0]  known_total;
    logic [CNT_W-1:0]  unknown_total;
    logic [COST_W-1:0] cost_low;
    logic [COST_W-1:0] cost_high;
    logic [SUM_W-1:0]  cost_total;
  } frame_stats_t;

  function automatic logic [U_W-1:0] feat_limit(input feat_e f);
    logic [U_W-1:0] lim;
    unique case (f)
      FEAT_SLOPE: lim = LIM_SLOPE;
      FEAT_ROUGH: lim = LIM_ROUGH;
      FEAT_STEP:  lim = LIM_STEP;
      FEAT_CLEAR: lim = LIM_CLEAR;
      FEAT_VAR:   lim = LIM_VAR;
      default:    lim = LIM_SLOPE;
    endcase
    return lim;
  endfunction

  function automatic logic [MUL_W-1:0] feat_recip(input feat_e f);
    logic [MUL_W-1:0] r;
    unique case (f)
      FEAT_SLOPE: r = RECIP_SLOPE;
      FEAT_ROUGH: r = RECIP_ROUGH;
      FEAT_STEP:  r = RECIP_STEP;
      FEAT_CLEAR: r = RECIP_CLEAR;
      FEAT_VAR:   r = RECIP_VAR;
      default:    r = RECIP_SLOPE;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/tcc_cell_if.sv
// Input channel of the traversability cost cell: valid/ready plus one cell.
// Depends on tcc_pkg for field widths.
interface tcc_cell_if;
  import tcc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SLOPE_W-1:0] slope_cdeg;
  logic signed [FEAT_W-1:0]  rough_um;
  logic signed [FEAT_W-1:0]  stepheight_um;
  logic signed [FEAT_W-1:0]  clear_um;
  logic signed [FEAT_W-1:0]  var_mm2;
  logic [OK_W-1:0]           feature_ok;
  logic                      last_cell;

  modport source (
    output valid, slope_cdeg, rough_um, stepheight_um, clear_um, var_mm2,
           feature_ok, last_cell,
    input  ready
  );

  modport sink (
    input  valid, slope_cdeg, rough_um, stepheight_um, clear_um, var_mm2,
           feature_ok, last_cell,
    output ready
  );
endinterface

>>> rtl/tcc_result_if.sv
// Result channel of the traversability cost cell: valid/ready plus one result.
// Depends on tcc_pkg for field widths.
interface tcc_result_if;
  import tcc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OCC_W-1:0] occupancy;
  logic                    frame_done;
  logic [CNT_W-1:0]        known_total;
  logic [CNT_W-1:0]        unknown_total;
  logic [COST_W-1:0]       cost_low;
  logic [COST_W-1:0]       cost_high;
  logic [SUM_W-1:0]        cost_total;

  modport source (
    output valid, occupancy, frame_done, known_total, unknown_total,
           cost_low, cost_high, cost_total,
    input  ready
  );

  modport sink (
    input  valid, occupancy, frame_done, known_total, unknown_total,
           cost_low, cost_high, cost_total,
    output ready
  );
endinterface

>>> rtl/traversability_cost_cell.sv
// Top level of the traversability cost cell.
// Depends on tcc_pkg, tcc_cell_if, tcc_result_if, tcc_cfg_regs, tcc_cost_seq
// and tcc_frame_stats.
//
// Each transfer on cell_i brings one grid cell with five terrain features and
// a validity mask; each transfer on result_o returns one occupancy value
// (0..100, or -1 when any feature is flagged invalid) and, on the cell marked
// last_cell, the frame's known/unknown counts and the min, max and saturating
// sum of the Q1.16 bounded cost, after which the frame totals restart. A
// new cell is taken only while the sequencer is idle. An unknown cell goes
// straight to the hand-off state; for a known cell a single 26x26 multiplier
// that a small sequencer reuses does the work: per feature it forms a
// reciprocal quotient estimate, multiplies back for a one-step correction and
// applies the weight, then it sums, clamps, scales to percent and rounds, and
// finally hands off and returns to idle. A result register sits at the
// output, so a new cell is taken while an earlier result still waits for
// result_o.ready. Weights live in an APB-style register file (pready always
// high): weight_slope at 0x00, weight_rough 0x04, weight_stepheight 0x08,
// weight_clear 0x0C, weight_var 0x10, each 16-bit unsigned Q0.16 in
// pwdata[15:0]; paddr[1:0] is ignored and other addresses read zero and
// ignore writes. Write weights only while no cell is in flight.
module traversability_cost_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tcc_cell_if.sink                       cell_i,
  tcc_result_if.source                   result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tcc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tcc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tcc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import tcc_pkg::*;

  weights_t     weights;
  cell_t        cell_pl;
  logic         seq_busy;
  logic         seq_done;
  logic         start;
  logic         load;
  cell_res_t    seq_res;
  logic signed [OCC_W-1:0] seq_occ;
  frame_stats_t stats_next;

  // Output register: valid is control, the rest is payload.
  logic                    out_valid_q;
  logic signed [OCC_W-1:0] occupancy_q;
  logic                    frame_done_q;
  frame_stats_t            stats_out_q;

  tcc_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .weights_o (weights)
  );

  // Pack the channel payload for the sequencer.
  assign cell_pl = '{slope_cdeg:    cell_i.slope_cdeg,
                     rough_um:      cell_i.rough_um,
                     stepheight_um: cell_i.stepheight_um,
                     clear_um:      cell_i.clear_um,
                     var_mm2:       cell_i.var_mm2,
                     feature_ok:    cell_i.feature_ok,
                     last_cell:     cell_i.last_cell};

  // Take a new cell whenever the sequencer is idle.
  assign cell_i.ready = ~seq_busy;
  assign start        = cell_i.valid & ~seq_busy;

  // Retire the finished cell once the output slot is free or draining.
  assign load = seq_done & (~out_valid_q | result_o.ready);

  tcc_cost_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .cell_i    (cell_pl),
    .weights_i (weights),
    .take_i    (load),
    .busy_o    (seq_busy),
    .done_o    (seq_done),
    .res_o     (seq_res),
    .occ_o     (seq_occ)
  );

  // Frame totals advance exactly once per retired cell.
  tcc_frame_stats u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (load),
    .res_i   (seq_res),
    .stats_o (stats_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Statistics are shown on the last cell only; otherwise drive zeros.
  always_ff @(posedge clk_i) begin
    if (load) begin
      occupancy_q  <= seq_occ;
      frame_done_q <= seq_res.last;
      stats_out_q  <= seq_res.last ? stats_next : '0;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.occupancy     = occupancy_q;
  assign result_o.frame_done    = frame_done_q;
  assign result_o.known_total   = stats_out_q.known_total;
  assign result_o.unknown_total = stats_out_q.unknown_total;
  assign result_o.cost_low      = stats_out_q.cost_low;
  assign result_o.cost_high     = stats_out_q.cost_high;
  assign result_o.cost_total    = stats_out_q.cost_total;
endmodule

>>> rtl/tcc_cfg_regs.sv
// APB-style weight registers of the traversability cost cell.
// Depends on tcc_pkg.
module tcc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [tcc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [tcc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output tcc_pkg::weights_t               weights_o
);
  import tcc_pkg::*;

  localparam int unsigned IDX_W = CFG_ADDR_W - 2;

  logic [IDX_W-1:0] reg_idx;
  logic             idx_hit;
  logic             wr_en;
  weights_t         weights_q;

  assign reg_idx   = paddr[CFG_ADDR_W-1:2];
  assign idx_hit   = reg_idx < IDX_W'(NUM_FEAT);
  assign wr_en     = psel & penable & pwrite;
  assign pready    = 1'b1;
  assign weights_o = weights_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q <= WEIGHTS_RST;
    end else if (wr_en && idx_hit) begin
      weights_q[reg_idx] <= pwdata[W_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx_hit) begin
      prdata = CFG_DATA_W'(weights_q[reg_idx]);
    end
  end
endmodule

>>> rtl/tcc_mul.sv
// Shared unsigned multiplier with registered product.
// Depends on tcc_pkg for operand widths.
module tcc_mul (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [tcc_pkg::MUL_W-1:0]   a_i,
  input  logic [tcc_pkg::MUL_W-1:0]   b_i,
  output logic [tcc_pkg::PROD_W-1:0]  prod_o
);
  import tcc_pkg::*;

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;
endmodule

>>> rtl/tcc_frame_stats.sv
// Per-frame counters, min, max and saturating sum of bounded cell costs.
// Depends on tcc_pkg.
module tcc_frame_stats (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  upd_i,
  input  tcc_pkg::cell_res_t    res_i,
  output tcc_pkg::frame_stats_t stats_o
);
  import tcc_pkg::*;

  logic [CNT_W-1:0]  known_q, known_d;
  logic [CNT_W-1:0]  unknown_q, unknown_d;
  logic [COST_W-1:0] min_q, min_d;
  logic [COST_W-1:0] max_q, max_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SUM_W-1:0]  sum_add;

  // Sum stays at or below 2^28, so adding one cost cannot overflow 29 bits.
  assign sum_add = sum_q + SUM_W'(res_i.cost);

  always_comb begin
    known_d   = known_q;
    unknown_d = unknown_q;
    min_d     = min_q;
    max_d     = max_q;
    sum_d     = sum_q;
    if (res_i.known) begin
      if (known_q < CNT_CAP) begin
        known_d = known_q + CNT_W'(1);
      end
      if (res_i.cost < min_q) begin
        min_d = res_i.cost;
      end
      if (res_i.cost > max_q) begin
        max_d = res_i.cost;
      end
      sum_d = (sum_add > SUM_CAP) ? SUM_CAP : sum_add;
    end else if (unknown_q < CNT_CAP) begin
      unknown_d = unknown_q + CNT_W'(1);
    end
  end

  // Report the totals including the cell being retired.
  assign stats_o = '{known_total:   known_d,
                     unknown_total: unknown_d,
                     cost_low:      min_d,
                     cost_high:     max_d,
                     cost_total:    sum_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_q   <= '0;
      unknown_q <= '0;
      min_q     <= ONE_Q16;
      max_q     <= '0;
      sum_q     <= '0;
    end else if (upd_i) begin
      if (res_i.last) begin
        known_q   <= '0;
        unknown_q <= '0;
        min_q     <= ONE_Q16;
        max_q     <= '0;
        sum_q     <= '0;
      end else begin
        known_q   <= known_d;
        unknown_q <= unknown_d;
        min_q     <= min_d;
        max_q     <= max_d;
        sum_q     <= sum_d;
      end
    end
  end

`ifndef SYNTH
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (known_q != '0) |-> (min_q <= max_q))
    else $error("frame min above frame max");

  a_sum_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i |=> (sum_q <= SUM_CAP))
    else $error("frame sum beyond its cap");

  a_counts_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i |=> ((known_q <= CNT_CAP) && (unknown_q <= CNT_CAP)))
    else $error("cell count beyond its cap");
`endif
endmodule

>>> rtl/tcc_cost_seq.sv
// Sequencer and datapath computing one cell's bounded cost and occupancy.
// Depends on tcc_pkg and tcc_mul (the shared multiplier).
module tcc_cost_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  tcc_pkg::cell_t                 cell_i,
  input  tcc_pkg::weights_t              weights_i,
  input  logic                           take_i,
  output logic                           busy_o,
  output logic                           done_o,
  output tcc_pkg::cell_res_t             res_o,
  output logic signed [tcc_pkg::OCC_W-1:0] occ_o
);
  import tcc_pkg::*;

  localparam int unsigned REM_W  = Q_LSB + COST_W;
  localparam int unsigned HI_W   = ACC_W - FRAC_W;
  localparam int unsigned OSUM_W = OCC_W + FRAC_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RECIP,
    S_BACK,
    S_FIX,
    S_WGT,
    S_SUM,
    S_OCC,
    S_ROUND,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  feat_e  feat_q, feat_d;
  logic   known_q, known_d;

  cell_t              cell_q;
  logic [COST_W-1:0]  q0_q;
  logic [COST_W-1:0]  norm_q;
  logic [ACC_W-1:0]   acc_q;
  logic [COST_W-1:0]  cost_q;
  logic [OCC_W-1:0]   occ_q;

  logic signed [FEAT_W:0] slope_x;
  logic signed [FEAT_W:0] feat_val;
  logic signed [FEAT_W:0] lim_s;
  logic [U_W-1:0]         lim;
  logic [U_W-1:0]         u_val;
  logic [REM_W-1:0]       num;
  logic [REM_W-1:0]       rem;
  logic                   fix_up;
  logic [COST_W-1:0]      q0_new;
  logic [COST_W-1:0]      q_fix;
  logic [COST_W-1:0]      norm_new;
  logic [ACC_W-1:0]       acc_sum;
  logic [HI_W-1:0]        acc_hi;
  logic [COST_W-1:0]      cost_new;
  logic [OSUM_W-1:0]      occ_sum;
  logic                   mul_en;
  logic [MUL_W-1:0]       mul_a;
  logic [MUL_W-1:0]       mul_b;
  logic [PROD_W-1:0]      prod;

  tcc_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Pick the feature under work; slope counts by magnitude.
  assign slope_x = (FEAT_W+1)'(cell_q.slope_cdeg);

  always_comb begin
    unique case (feat_q)
      FEAT_SLOPE: feat_val = (slope_x < 0) ? -slope_x : slope_x;
      FEAT_ROUGH: feat_val = (FEAT_W+1)'(cell_q.rough_um);
      FEAT_STEP:  feat_val = (FEAT_W+1)'(cell_q.stepheight_um);
      FEAT_CLEAR: feat_val = (FEAT_W+1)'(cell_q.clear_um);
      FEAT_VAR:   feat_val = (FEAT_W+1)'(cell_q.var_mm2);
      default:    feat_val = '0;
    endcase
  end

  // Clamp to [0, limit]; clearance then maps to one minus the ratio.
  assign lim   = feat_limit(feat_q);
  assign lim_s = $signed({{(FEAT_W+1-U_W){1'b0}}, lim});

  always_comb begin
    if (feat_val <= 0) begin
      u_val = '0;
    end else if (feat_val > lim_s) begin
      u_val = lim;
    end else begin
      u_val = feat_val[U_W-1:0];
    end
  end

  // Quotient estimate and the remainder check that adds the missing one.
  assign q0_new   = prod[REM_W-1:Q_LSB];
  assign num      = {1'b0, u_val, {FRAC_W{1'b0}}};
  assign rem      = num - prod[REM_W-1:0];
  assign fix_up   = rem >= REM_W'(lim);
  assign q_fix    = q0_q + COST_W'(fix_up);
  assign norm_new = (feat_q == FEAT_CLEAR) ? (ONE_Q16 - q_fix) : q_fix;

  assign acc_sum  = acc_q + ACC_W'(prod[31:0]);
  assign acc_hi   = acc_q[ACC_W-1:FRAC_W];
  assign cost_new = (acc_hi > HI_W'(ONE_Q16)) ? ONE_Q16 : acc_hi[COST_W-1:0];
  assign occ_sum  = prod[OSUM_W-1:0] + OSUM_W'(32768);

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_RECIP: begin
        mul_a = MUL_W'(u_val);
        mul_b = feat_recip(feat_q);
      end
      S_BACK: begin
        mul_a = MUL_W'(q0_new);
        mul_b = MUL_W'(lim);
      end
      S_WGT: begin
        mul_a = MUL_W'(norm_q);
        mul_b = MUL_W'(weights_i[feat_q]);
      end
      S_OCC: begin
        mul_a = MUL_W'(cost_new);
        mul_b = MUL_W'(OCC_SCALE);
      end
      S_IDLE, S_FIX, S_SUM, S_ROUND, S_DONE: begin
        mul_en = 1'b0;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    feat_d  = feat_q;
    known_d = known_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          feat_d  = FEAT_SLOPE;
          known_d = (cell_i.feature_ok == ALL_OK);
          state_d = (cell_i.feature_ok == ALL_OK) ? S_RECIP : S_DONE;
        end
      end
      S_RECIP: state_d = S_BACK;
      S_BACK:  state_d = S_FIX;
      S_FIX:   state_d = S_WGT;
      S_WGT: begin
        if (feat_q == FEAT_VAR) begin
          state_d = S_SUM;
        end else begin
          feat_d  = feat_e'(feat_q + 3'd1);
          state_d = S_RECIP;
        end
      end
      S_SUM:   state_d = S_OCC;
      S_OCC:   state_d = S_ROUND;
      S_ROUND: state_d = S_DONE;
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      feat_q  <= FEAT_SLOPE;
      known_q <= 1'b0;
    end else begin
      state_q <= state_d;
      feat_q  <= feat_d;
      known_q <= known_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      cell_q <= cell_i;
      acc_q  <= '0;
    end
    // Fold in the previous feature's weighted term.
    if ((state_q == S_RECIP && feat_q != FEAT_SLOPE) || state_q == S_SUM) begin
      acc_q <= acc_sum;
    end
    if (state_q == S_BACK) begin
      q0_q <= q0_new;
    end
    if (state_q == S_FIX) begin
      norm_q <= norm_new;
    end
    if (state_q == S_OCC) begin
      cost_q <= cost_new;
    end
    if (state_q == S_ROUND) begin
      occ_q <= occ_sum[OSUM_W-1:FRAC_W];
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign res_o  = '{known: known_q, last: cell_q.last_cell, cost: cost_q};
  assign occ_o  = known_q ? $signed(occ_q) : OCC_UNKNOWN;

`ifndef SYNTH
  a_recip_within_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIX) |-> (rem < (REM_W'(lim) << 1)))
    else $error("reciprocal estimate off by more than one");

  a_norm_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WGT) |-> (norm_q <= ONE_Q16))
    else $error("normalized term above one");

  a_occ_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && known_q) |-> (occ_q <= OCC_W'(100)))
    else $error("occupancy above one hundred");
`endif
endmodule
